### rtl/core/stb_pkg.sv
// Shared types, request codes and default sizes for the software timer bank.
package stb_pkg;

  // Default bank size and counter width
  localparam int unsigned DefNumTimers  = 16;
  localparam int unsigned DefCountWidth = 32;

  // Fixed field widths
  localparam int unsigned ReqW   = 4;
  localparam int unsigned IdW    = 4;
  localparam int unsigned ValueW = 32;

  // Request codes carried in req_type
  typedef enum logic [ReqW-1:0] {
    REQ_TICK   = 4'd0,
    REQ_CREATE = 4'd1,
    REQ_RESET  = 4'd2,
    REQ_START  = 4'd3,
    REQ_STOP   = 4'd4,
    REQ_CHECK  = 4'd5,
    REQ_READ   = 4'd6,
    REQ_SET    = 4'd7,
    REQ_ACTIVE = 4'd8
  } req_type_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;   // capture the input transaction into the request register
    logic exec;   // execute the held request and fill the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_blocked;  // output register holds a result that is not taken this cycle
  } sts_t;

endpackage

### rtl/core/stb_ctrl.sv
// Controller state machine: sequences request capture and execution.
module stb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  stb_pkg::sts_t sts_i,
  output stb_pkg::cmd_t cmd_o
);
  import stb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_BUSY = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   exec;
  logic   load;

  // Execute the held request once the output register can take its result
  assign exec       = (state_q == ST_BUSY) && !sts_i.out_blocked;
  assign in_stall_o = (state_q == ST_BUSY) && sts_i.out_blocked;
  assign load       = in_valid_i && !in_stall_o;

  assign cmd_o.load = load;
  assign cmd_o.exec = exec;

  // Advance the state: busy while a request sits in the request register
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (load) state_d = ST_BUSY;
      end
      ST_BUSY: begin
        if (exec && !load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A new transaction never overwrites a request that has not executed
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && state_q == ST_BUSY) |-> exec)
    else $error("request register overwritten before execution");

  // Execution only happens on a held request
  a_exec_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec |-> (state_q == ST_BUSY) && !sts_i.out_blocked)
    else $error("execute without a held request or with blocked output");

endmodule

### rtl/core/stb_datapath.sv
// Datapath: request register, counter bank, run flags, allocator and output register.
module stb_datapath #(
  parameter int unsigned NUM_TIMERS  = stb_pkg::DefNumTimers,
  parameter int unsigned COUNT_WIDTH = stb_pkg::DefCountWidth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  stb_pkg::cmd_t               cmd_i,
  output stb_pkg::sts_t               sts_o,
  input  logic [stb_pkg::ReqW-1:0]    req_type_i,
  input  logic [stb_pkg::IdW-1:0]     timer_id_i,
  input  logic [stb_pkg::ValueW-1:0]  value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        status_o,
  output logic [stb_pkg::IdW-1:0]     new_id_o,
  output logic [stb_pkg::ValueW-1:0]  count_value_o,
  output logic                        timed_out_o,
  output logic                        is_active_o
);
  import stb_pkg::*;

  localparam int unsigned IdxW   = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned AllocW = $clog2(NUM_TIMERS + 1);
  localparam int unsigned CmpW   = (COUNT_WIDTH > ValueW) ? COUNT_WIDTH : ValueW;

  // Request register
  logic [ReqW-1:0]   req_q;
  logic [IdW-1:0]    id_q;
  logic [ValueW-1:0] val_q;

  // Timer state
  logic [COUNT_WIDTH-1:0] cnt_q [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] cnt_d [NUM_TIMERS];
  logic [NUM_TIMERS-1:0]  run_q, run_d;
  logic [AllocW-1:0]      alloc_q, alloc_d;

  // Output register
  logic              out_valid_q;
  logic              status_q;
  logic [IdW-1:0]    new_id_q;
  logic [ValueW-1:0] count_q;
  logic              tout_q;
  logic              act_q;

  // Addressing and selected entry
  logic [AllocW+IdW-1:0]  id_ext;
  logic [AllocW+IdW-1:0]  alloc_ext;
  logic [IdxW+IdW-1:0]    idx_ext;
  logic [IdxW-1:0]        idx;
  logic                   known;
  logic                   full;
  logic [COUNT_WIDTH-1:0] sel_cnt;
  logic [CmpW-1:0]        sel_ext;
  logic [CmpW-1:0]        val_ext;

  // Result of the held request
  logic              res_status;
  logic [IdW-1:0]    res_new_id;
  logic [ValueW-1:0] res_count;
  logic              res_tout;
  logic              res_act;

  // Capture the input transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_type_i;
      id_q  <= timer_id_i;
      val_q <= value_i;
    end
  end

  // Decode the addressed timer
  assign id_ext    = {{AllocW{1'b0}}, id_q};
  assign alloc_ext = {{IdW{1'b0}}, alloc_q};
  assign idx_ext   = {{IdxW{1'b0}}, id_q};
  assign idx       = idx_ext[IdxW-1:0];
  assign known     = id_ext < alloc_ext;
  assign full      = alloc_q == AllocW'(NUM_TIMERS);
  assign sel_cnt   = cnt_q[idx];
  assign sel_ext   = CmpW'(sel_cnt);
  assign val_ext   = CmpW'(val_q);

  // Work out the next timer state and the result
  always_comb begin
    cnt_d      = cnt_q;
    run_d      = run_q;
    alloc_d    = alloc_q;
    res_status = 1'b0;
    res_new_id = '0;
    res_count  = '0;
    res_tout   = 1'b0;
    res_act    = 1'b0;
    case (req_q)
      REQ_TICK: begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (run_q[i]) cnt_d[i] = cnt_q[i] + COUNT_WIDTH'(1);
        end
      end
      REQ_CREATE: begin
        if (full) begin
          res_status = 1'b1;
        end else begin
          res_new_id = alloc_ext[IdW-1:0];
          alloc_d    = alloc_q + AllocW'(1);
        end
      end
      REQ_RESET, REQ_START, REQ_STOP, REQ_CHECK, REQ_READ, REQ_SET, REQ_ACTIVE: begin
        if (!known) begin
          res_status = 1'b1;
        end else begin
          case (req_q)
            REQ_RESET:  cnt_d[idx] = '0;
            REQ_START:  run_d[idx] = 1'b1;
            REQ_STOP:   run_d[idx] = 1'b0;
            REQ_CHECK:  res_tout   = sel_ext >= val_ext;
            REQ_READ:   res_count  = sel_ext[ValueW-1:0];
            REQ_SET:    cnt_d[idx] = val_ext[COUNT_WIDTH-1:0];
            REQ_ACTIVE: res_act    = run_q[idx];
            default:    res_status = 1'b1;
          endcase
        end
      end
      default: res_status = 1'b1;
    endcase
  end

  // Commit the timer state on execution
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TIMERS; i++) cnt_q[i] <= '0;
      run_q   <= '0;
      alloc_q <= '0;
    end else if (cmd_i.exec) begin
      cnt_q   <= cnt_d;
      run_q   <= run_d;
      alloc_q <= alloc_d;
    end
  end

  // Hold the result until the output transaction completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q <= res_status;
      new_id_q <= res_new_id;
      count_q  <= res_count;
      tout_q   <= res_tout;
      act_q    <= res_act;
    end
  end

  assign sts_o.out_blocked = out_valid_q && out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign new_id_o      = new_id_q;
  assign count_value_o = count_q;
  assign timed_out_o   = tout_q;
  assign is_active_o   = act_q;

  // Execution always leaves a result in the output register
  a_exec_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec |=> out_valid_q)
    else $error("executed request left no result");

  // The allocator never passes the bank size
  a_alloc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alloc_q <= AllocW'(NUM_TIMERS))
    else $error("allocation count beyond bank size");

  // A create with room hands out exactly one id
  a_create_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && req_q == REQ_CREATE && !full)
      |=> alloc_q == $past(alloc_q) + AllocW'(1))
    else $error("create did not advance the allocator by one");

endmodule

### rtl/core/software_timer_bank_core.sv
// Top level of the software timer bank: controller plus datapath.
//
// A bank of NUM_TIMERS tick counters of COUNT_WIDTH bits, each with a run
// flag, all cleared at reset with no clearing pass. Each request transaction
// gives exactly one result transaction. A request is captured into a request
// register and executed against the flip-flop counter bank once the output
// register can take its result; execution writes the result into the output
// register, which drives output valid. A new request is taken in the same
// cycle that the held one executes, so the sustained rate is one request
// per cycle while the output is not stalled; the input stalls only while a
// request is held and the output register is full and stalled. Ids are
// handed out in order from 0 upward; requests for ids not yet handed out,
// creates on a full bank and undefined request codes return status 1 and
// change nothing.
module software_timer_bank_core #(
  parameter int unsigned NUM_TIMERS  = stb_pkg::DefNumTimers,
  parameter int unsigned COUNT_WIDTH = stb_pkg::DefCountWidth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [stb_pkg::ReqW-1:0]    req_type_i,
  input  logic [stb_pkg::IdW-1:0]     timer_id_i,
  input  logic [stb_pkg::ValueW-1:0]  value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        status_o,
  output logic [stb_pkg::IdW-1:0]     new_id_o,
  output logic [stb_pkg::ValueW-1:0]  count_value_o,
  output logic                        timed_out_o,
  output logic                        is_active_o
);
  import stb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequence capture and execution
  stb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold the timers and compute results
  stb_datapath #(
    .NUM_TIMERS  (NUM_TIMERS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .req_type_i    (req_type_i),
    .timer_id_i    (timer_id_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .new_id_o      (new_id_o),
    .count_value_o (count_value_o),
    .timed_out_o   (timed_out_o),
    .is_active_o   (is_active_o)
  );

endmodule

### bench/tb.sv
// Self-checking testbench for the software timer bank core.
`timescale 1ns / 100ps

module tb;
  import stb_pkg::*;

  localparam int unsigned NumTimers = DefNumTimers;
  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned LongHold  = 300;
  localparam int unsigned MaxShown  = 10;
  localparam int unsigned DrainWait = 8;

  localparam logic StatusOk  = 1'b0;
  localparam logic StatusErr = 1'b1;

  localparam logic [ReqW-1:0] FirstUndefReq = 4'd9;
  localparam logic [ReqW-1:0] LastUndefReq  = 4'd15;

  localparam logic [ValueW-1:0] AllOnes = {ValueW{1'b1}};

  // One result transaction as the block presents it
  typedef struct packed {
    logic              status;
    logic [IdW-1:0]    new_id;
    logic [ValueW-1:0] count;
    logic              timed_out;
    logic              is_active;
  } timer_result_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              in_valid_i    = 1'b0;
  logic              in_stall_o;
  logic [ReqW-1:0]   req_type_i    = '0;
  logic [IdW-1:0]    timer_id_i    = '0;
  logic [ValueW-1:0] value_i       = '0;
  logic              out_valid_o;
  logic              out_stall_i   = 1'b0;
  logic              status_o;
  logic [IdW-1:0]    new_id_o;
  logic [ValueW-1:0] count_value_o;
  logic              timed_out_o;
  logic              is_active_o;

  // Local copy of the timer bank state
  logic [ValueW-1:0] model_count [NumTimers];
  logic              model_run   [NumTimers];
  int unsigned       model_alloc;

  timer_result_t pending_results [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left     = 0;
  int unsigned idle_cycles   = 0;
  int unsigned n_sent        = 0;
  int unsigned n_checked     = 0;
  int unsigned n_err_resp    = 0;
  int unsigned n_timeouts    = 0;
  int unsigned mismatches    = 0;

  software_timer_bank_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .timer_id_i    (timer_id_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .new_id_o      (new_id_o),
    .count_value_o (count_value_o),
    .timed_out_o   (timed_out_o),
    .is_active_o   (is_active_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Work out the result of one request and advance the local bank state
  function automatic timer_result_t predict_request(input logic [ReqW-1:0]   req,
                                                    input logic [IdW-1:0]    id,
                                                    input logic [ValueW-1:0] val);
    timer_result_t res;
    int unsigned   i;
    res = '0;
    case (req)
      REQ_TICK: begin
        for (i = 0; i < model_alloc; i++)
          if (model_run[i]) model_count[i] = model_count[i] + 1'b1;
      end
      REQ_CREATE: begin
        if (model_alloc < NumTimers) begin
          res.new_id = model_alloc[IdW-1:0];
          model_alloc++;
        end else begin
          res.status = StatusErr;
        end
      end
      REQ_RESET, REQ_START, REQ_STOP, REQ_CHECK, REQ_READ, REQ_SET, REQ_ACTIVE: begin
        if (id >= model_alloc) begin
          res.status = StatusErr;
        end else begin
          case (req)
            REQ_RESET:  model_count[id] = '0;
            REQ_START:  model_run[id] = 1'b1;
            REQ_STOP:   model_run[id] = 1'b0;
            REQ_CHECK:  res.timed_out = (model_count[id] >= val);
            REQ_READ:   res.count = model_count[id];
            REQ_SET:    model_count[id] = val;
            default:    res.is_active = model_run[id];
          endcase
        end
      end
      default: res.status = StatusErr;
    endcase
    return res;
  endfunction

  // Offer one request transaction and record its expected result on acceptance
  task automatic send_request(input logic [ReqW-1:0]   req,
                              input logic [IdW-1:0]    id,
                              input logic [ValueW-1:0] val);
    timer_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    timer_id_i <= id;
    value_i    <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    res = predict_request(req, id, val);
    pending_results.push_back(res);
    n_sent++;
    @(negedge clk_i);
  endtask

  // Weighted random requests; ids and values lean toward live timers and counts
  task automatic random_traffic(input int unsigned n_items, input int unsigned create_pct);
    logic [ReqW-1:0]   req;
    logic [IdW-1:0]    id;
    logic [ValueW-1:0] val;
    int unsigned       pick;
    repeat (n_items) begin
      pick = $urandom_range(99);
      if (pick < create_pct) begin
        req = REQ_CREATE;
      end else begin
        pick = $urandom_range(99);
        if (pick < 28)      req = REQ_TICK;
        else if (pick < 38) req = REQ_START;
        else if (pick < 44) req = REQ_STOP;
        else if (pick < 54) req = REQ_SET;
        else if (pick < 66) req = REQ_READ;
        else if (pick < 80) req = REQ_CHECK;
        else if (pick < 87) req = REQ_ACTIVE;
        else if (pick < 93) req = REQ_RESET;
        else                req = ReqW'($urandom_range(FirstUndefReq, LastUndefReq));
      end
      if (model_alloc != 0 && $urandom_range(3) != 0) begin
        id = IdW'($urandom_range(model_alloc - 1));
      end else begin
        id = IdW'($urandom_range(NumTimers - 1));
      end
      case ($urandom_range(3))
        0:       val = model_count[id] + $urandom_range(4) - 32'd2;
        1:       val = $urandom_range(1) ? AllOnes : '0;
        2:       val = AllOnes - $urandom_range(8);
        default: val = $urandom();
      endcase
      send_request(req, id, val);
    end
  endtask

  // Drive the receiver stall: a long hold when requested, else random stalls
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Compare each result transaction with the oldest pending expectation
  always @(posedge clk_i) begin
    timer_result_t got;
    timer_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {status_o, new_id_o, count_value_o, timed_out_o, is_active_o};
      n_checked++;
      if (got.status) n_err_resp++;
      if (got.timed_out) n_timeouts++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxShown)
          $display("tb: result with nothing pending: status %0b new_id %0d count %h",
                   got.status, got.new_id, got.count);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MaxShown) begin
            $display("tb: mismatch at result %0d (exp/act): status %0b/%0b new_id %0d/%0d",
                     n_checked, want.status, got.status, want.new_id, got.new_id);
            $display("tb:   count %h/%h timed_out %0b/%0b active %0b/%0b",
                     want.count, got.count, want.timed_out, got.timed_out,
                     want.is_active, got.is_active);
          end
        end
      end
    end
  end

  // End the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("tb: watchdog: no transaction in %0d cycles", IdleLimit);
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  // Corner cases: empty bank, unknown ids, wrap, compare extremes, undefined codes
  task automatic test_directed();
    send_request(REQ_TICK,   4'd0,  '0);
    send_request(REQ_READ,   4'd0,  '0);
    send_request(REQ_START,  4'd15, AllOnes);
    send_request(REQ_CREATE, 4'd0,  '0);
    send_request(REQ_CREATE, 4'd0,  '0);
    send_request(REQ_SET,    4'd0,  AllOnes);
    send_request(REQ_START,  4'd0,  '0);
    send_request(REQ_ACTIVE, 4'd0,  '0);
    send_request(REQ_TICK,   4'd0,  '0);
    send_request(REQ_READ,   4'd0,  '0);
    send_request(REQ_CHECK,  4'd0,  '0);
    send_request(REQ_CHECK,  4'd0,  AllOnes);
    send_request(REQ_SET,    4'd1,  AllOnes - 1'b1);
    send_request(REQ_START,  4'd1,  '0);
    send_request(REQ_TICK,   4'd0,  '0);
    send_request(REQ_CHECK,  4'd1,  AllOnes);
    send_request(REQ_READ,   4'd1,  '0);
    send_request(REQ_STOP,   4'd1,  '0);
    send_request(REQ_ACTIVE, 4'd1,  '0);
    send_request(REQ_RESET,  4'd1,  '0);
    send_request(REQ_READ,   4'd1,  '0);
    send_request(REQ_SET,    4'd2,  32'h5A5A_5A5A);
    send_request(FirstUndefReq, 4'd0, '0);
    send_request(LastUndefReq,  4'd1, 32'hA5A5_A5A5);
  endtask

  // Requests while the bank fills slowly, with some ids not yet handed out
  task automatic test_unallocated_ids();
    random_traffic(500, 2);
  endtask

  // Fill the bank, then ask for more timers than it holds
  task automatic test_bank_full();
    while (model_alloc < NumTimers) send_request(REQ_CREATE, '0, '0);
    send_request(REQ_CREATE, 4'd15, AllOnes);
    send_request(REQ_CREATE, 4'd0, '0);
  endtask

  // Full bank with random requests across every code
  task automatic test_mixed_traffic(input int unsigned n_items);
    random_traffic(n_items, 3);
  endtask

  // Hold the output for a long stretch so the block backs up into its input
  task automatic test_output_backpressure();
    hold_left = LongHold;
    random_traffic(80, 2);
  endtask

  initial begin
    for (int i = 0; i < NumTimers; i++) begin
      model_count[i] = '0;
      model_run[i]   = 1'b0;
    end
    model_alloc = 0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 25;
    recv_idle_pct = 57;
    test_directed();
    test_unallocated_ids();

    send_idle_pct = 57;
    recv_idle_pct = 25;
    test_bank_full();
    test_mixed_traffic(450);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_backpressure();
    test_mixed_traffic(700);
    in_valid_i <= 1'b0;

    // Drain outstanding results, then keep watching for stray results
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("tb: %0d requests, %0d results checked, %0d error replies, %0d timeouts seen",
             n_sent, n_checked, n_err_resp, n_timeouts);
    $display("tb: idle mixes 25/57, 57/25, none, plus a %0d-cycle output hold; %0d mismatches",
             LongHold, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
